@@ design/slru_pkg.sv @@
// ----------------------------------------------------------------------------
// Segmented LRU replacement package
// Sizes, state encoding and controller command type shared by the core.
// ----------------------------------------------------------------------------
package slru_pkg;

  localparam int ENTRIES           = 16;
  localparam int PROTECTED_ENTRIES = ENTRIES >> 1;

  localparam int PROT_CAP = (PROTECTED_ENTRIES < ENTRIES) ? PROTECTED_ENTRIES : (ENTRIES - 1);
  localparam int PROB_CAP = ENTRIES - PROT_CAP;

  localparam int KEY_W      = 64;
  localparam int SLOT_OUT_W = 4;
  localparam int SLOT_W     = $clog2(ENTRIES);
  localparam int USED_W     = $clog2(ENTRIES + 1);
  localparam int PCNT_W     = $clog2(PROT_CAP + 1);
  localparam int BCNT_W     = $clog2(PROB_CAP + 1);
  localparam int PPOS_W     = (PROT_CAP > 1) ? $clog2(PROT_CAP) : 1;
  localparam int BPOS_W     = (PROB_CAP > 1) ? $clog2(PROB_CAP) : 1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } cmd_t;

endpackage

@@ design/segmented_lru_replacement_core.sv @@
// ----------------------------------------------------------------------------
// Segmented LRU replacement core
// Looks up a key over all slots and keeps protected and probationary
// recency lists, answering with a hit flag and the slot that holds the key.
// ----------------------------------------------------------------------------
// Channel  | Ports                         | Transfer
// input    | start, busy, in_key           | start high while busy is low
// result   | out_valid, out_hit, out_slot  | out_valid high for one cycle
//
// Each access passes through accept, tag compare, list update and response,
// after which the next access may be accepted. Busy is high from the cycle
// after acceptance until the response cycle ends.
// After reset all lists are empty and no slot is in use; no clearing pass.
// The receiver cannot stall, so a result is never held back.
// ----------------------------------------------------------------------------
module segmented_lru_replacement_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [slru_pkg::KEY_W-1:0]          in_key,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [slru_pkg::SLOT_OUT_W-1:0]     out_slot
);

  slru_pkg::cmd_t cmd;

  slru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  slru_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_key   (in_key),
    .out_hit  (out_hit),
    .out_slot (out_slot)
  );

endmodule

@@ design/slru_ctrl.sv @@
// ----------------------------------------------------------------------------
// Segmented LRU controller
// Sequences load, compare, update and response for one access at a time.
// ----------------------------------------------------------------------------
module slru_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output slru_pkg::cmd_t  cmd
);

  slru_pkg::state_t state_r;
  slru_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slru_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = slru_pkg::ST_CMP;
        end
      end
      slru_pkg::ST_CMP:  state_nxt = slru_pkg::ST_UPD;
      slru_pkg::ST_UPD:  state_nxt = slru_pkg::ST_RESP;
      slru_pkg::ST_RESP: state_nxt = slru_pkg::ST_IDLE;
      default:           state_nxt = slru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slru_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != slru_pkg::ST_IDLE);
  assign out_valid   = (state_r == slru_pkg::ST_RESP);
  assign cmd.load    = (state_r == slru_pkg::ST_IDLE) && start;
  assign cmd.compare = (state_r == slru_pkg::ST_CMP);
  assign cmd.update  = (state_r == slru_pkg::ST_UPD);

endmodule

@@ design/slru_dp.sv @@
// ----------------------------------------------------------------------------
// Segmented LRU datapath
// Slot tags, parallel tag compare and the two recency lists with counts.
// ----------------------------------------------------------------------------
module slru_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  slru_pkg::cmd_t                    cmd,
  input  logic [slru_pkg::KEY_W-1:0]        in_key,
  output logic                              out_hit,
  output logic [slru_pkg::SLOT_OUT_W-1:0]   out_slot
);

  localparam int N      = slru_pkg::ENTRIES;
  localparam int P      = slru_pkg::PROT_CAP;
  localparam int B      = slru_pkg::PROB_CAP;
  localparam int SLOT_W = slru_pkg::SLOT_W;
  localparam int USED_W = slru_pkg::USED_W;
  localparam int PCNT_W = slru_pkg::PCNT_W;
  localparam int BCNT_W = slru_pkg::BCNT_W;
  localparam int PPOS_W = slru_pkg::PPOS_W;
  localparam int BPOS_W = slru_pkg::BPOS_W;

  logic [slru_pkg::KEY_W-1:0] key_r;
  logic [slru_pkg::KEY_W-1:0] tags_r [N];
  logic [USED_W-1:0]          used_r;
  logic [USED_W-1:0]          used_nxt;
  slru_pkg::slot_t            prot_r   [P];
  slru_pkg::slot_t            prot_nxt [P];
  slru_pkg::slot_t            prob_r   [B];
  slru_pkg::slot_t            prob_nxt [B];
  logic [PCNT_W-1:0]          pcnt_r;
  logic [PCNT_W-1:0]          pcnt_nxt;
  logic [BCNT_W-1:0]          bcnt_r;
  logic [BCNT_W-1:0]          bcnt_nxt;
  logic [N-1:0]               pflag_r;
  logic [N-1:0]               pflag_nxt;

  logic                       hit_r;
  logic                       inprot_r;
  slru_pkg::slot_t            hslot_r;
  logic                       res_hit_r;
  logic [slru_pkg::SLOT_OUT_W-1:0] res_slot_r;

  logic [N-1:0]               match;
  slru_pkg::slot_t            hslot;

  always_comb begin
    hslot = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = (USED_W'(i) < used_r) && (tags_r[i] == key_r);
      if (match[i]) begin
        hslot = hslot | SLOT_W'(i);
      end
    end
  end

  // Update decisions.
  logic               prot_full;
  logic               fresh;
  slru_pkg::slot_t    mslot;
  logic [PPOS_W-1:0]  ppos;
  logic [BPOS_W-1:0]  bpos;
  logic               p_rm_en;
  logic [PPOS_W-1:0]  p_rm_pos;
  logic               p_app_en;
  logic               b_rm_en;
  logic [BPOS_W-1:0]  b_rm_pos;
  logic               b_app_en;
  slru_pkg::slot_t    b_app_val;
  slru_pkg::slot_t    prot_rm [P];
  slru_pkg::slot_t    prob_rm [B];
  logic [PCNT_W-1:0]  pcnt_rm;
  logic [BCNT_W-1:0]  bcnt_rm;

  always_comb begin
    prot_full = (pcnt_r == PCNT_W'(P));
    fresh     = (used_r < USED_W'(N)) && (bcnt_r < BCNT_W'(B));
    if (fresh) begin
      mslot = used_r[SLOT_W-1:0];
    end else if (bcnt_r != '0) begin
      mslot = prob_r[0];
    end else begin
      mslot = '0;
    end

    ppos = '0;
    for (int j = 0; j < P; j++) begin
      if ((PCNT_W'(j) < pcnt_r) && (prot_r[j] == hslot_r)) begin
        ppos = ppos | PPOS_W'(j);
      end
    end
    bpos = '0;
    for (int j = 0; j < B; j++) begin
      if ((BCNT_W'(j) < bcnt_r) && (prob_r[j] == hslot_r)) begin
        bpos = bpos | BPOS_W'(j);
      end
    end

    p_rm_en   = hit_r && (inprot_r || prot_full);
    p_rm_pos  = inprot_r ? ppos : '0;
    p_app_en  = hit_r;
    b_rm_en   = hit_r ? !inprot_r : (!fresh && (bcnt_r != '0));
    b_rm_pos  = hit_r ? bpos : '0;
    b_app_en  = hit_r ? (!inprot_r && prot_full) : 1'b1;
    b_app_val = hit_r ? prot_r[0] : mslot;

    for (int j = 0; j < P; j++) begin
      if (p_rm_en && (PPOS_W'(j) >= p_rm_pos) && (j + 1 < P)) begin
        prot_rm[j] = prot_r[(j + 1 < P) ? j + 1 : j];
      end else begin
        prot_rm[j] = prot_r[j];
      end
    end
    pcnt_rm = pcnt_r - PCNT_W'(p_rm_en);
    for (int j = 0; j < P; j++) begin
      if (p_app_en && (pcnt_rm < PCNT_W'(P)) && (PCNT_W'(j) == pcnt_rm)) begin
        prot_nxt[j] = hslot_r;
      end else begin
        prot_nxt[j] = prot_rm[j];
      end
    end
    pcnt_nxt = pcnt_rm + PCNT_W'(p_app_en && (pcnt_rm < PCNT_W'(P)));

    for (int j = 0; j < B; j++) begin
      if (b_rm_en && (BPOS_W'(j) >= b_rm_pos) && (j + 1 < B)) begin
        prob_rm[j] = prob_r[(j + 1 < B) ? j + 1 : j];
      end else begin
        prob_rm[j] = prob_r[j];
      end
    end
    bcnt_rm = bcnt_r - BCNT_W'(b_rm_en);
    for (int j = 0; j < B; j++) begin
      if (b_app_en && (bcnt_rm < BCNT_W'(B)) && (BCNT_W'(j) == bcnt_rm)) begin
        prob_nxt[j] = b_app_val;
      end else begin
        prob_nxt[j] = prob_rm[j];
      end
    end
    bcnt_nxt = bcnt_rm + BCNT_W'(b_app_en && (bcnt_rm < BCNT_W'(B)));

    pflag_nxt = pflag_r;
    if (hit_r) begin
      if (!inprot_r) begin
        if (prot_full) begin
          pflag_nxt[prot_r[0]] = 1'b0;
        end
        pflag_nxt[hslot_r] = 1'b1;
      end
    end else begin
      pflag_nxt[mslot] = 1'b0;
    end

    used_nxt = used_r + USED_W'(!hit_r && fresh);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
    end
    if (cmd.compare) begin
      hit_r    <= |match;
      hslot_r  <= hslot;
      inprot_r <= pflag_r[hslot];
    end
    if (cmd.update) begin
      if (!hit_r) begin
        tags_r[mslot] <= key_r;
      end
      for (int j = 0; j < P; j++) begin
        prot_r[j] <= prot_nxt[j];
      end
      for (int j = 0; j < B; j++) begin
        prob_r[j] <= prob_nxt[j];
      end
      res_hit_r  <= hit_r;
      res_slot_r <= slru_pkg::SLOT_OUT_W'(hit_r ? hslot_r : mslot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      pcnt_r  <= '0;
      bcnt_r  <= '0;
      pflag_r <= '0;
    end else if (cmd.update) begin
      used_r  <= used_nxt;
      pcnt_r  <= pcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      pflag_r <= pflag_nxt;
    end
  end

  assign out_hit  = res_hit_r;
  assign out_slot = res_slot_r;

endmodule
